// File: rtl/core/fbc_pkg.sv
package fbc_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int PLANE_COUNT     = 6;
  localparam int AXIS_COUNT      = 3;
  localparam int VEC_COUNT       = 4;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TEST = 1'b1;

  typedef struct packed {
    logic clear;
    logic load;
    logic check;
  } fbc_ctl_t;

endpackage

// File: rtl/core/fbc_plane_unit.sv
module fbc_plane_unit #(
  parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = fbc_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fbc_pkg::fbc_ctl_t             ctl,
  input  logic signed [COORD_WIDTH:0]   plane [4],
  input  logic signed [COORD_WIDTH-1:0] box_lo [3],
  input  logic signed [COORD_WIDTH-1:0] box_hi [3],
  output logic                          all_pass
);
  import fbc_pkg::*;

  localparam int PW  = COORD_WIDTH + 1;
  localparam int PRW = PW + COORD_WIDTH;
  localparam int SW  = 2 * COORD_WIDTH + 4;

  logic signed [COORD_WIDTH-1:0] corner [AXIS_COUNT];
  logic signed [PRW-1:0]         prod [AXIS_COUNT];
  logic signed [PW-1:0]          d_q;
  logic signed [SW-1:0]          sum;
  logic                          pass;

  // p-vertex: max corner where the plane component is strictly positive
  always_comb begin
    for (int k = 0; k < AXIS_COUNT; k++) begin
      corner[k] = (!plane[k][PW-1] && (|plane[k])) ? box_hi[k] : box_lo[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int k = 0; k < AXIS_COUNT; k++) begin
        prod[k] <= PRW'(plane[k]) * PRW'(corner[k]);
      end
      d_q <= plane[3];
    end
  end

  always_comb begin
    sum = SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]) + (SW'(d_q) <<< FRAC_BITS);
    pass = !sum[SW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      all_pass <= 1'b1;
    end else if (ctl.clear) begin
      all_pass <= 1'b1;
    end else if (ctl.check) begin
      all_pass <= all_pass & pass;
    end
  end

endmodule

// File: rtl/core/frustum_box_cull.sv
// Frustum culling of axis-aligned boxes, signed fixed point.
// Input channel (in_valid/in_ready) takes one word per accept. A word with
// action = load writes matrix vector vec_index from vx..vw; it gives no result
// and the block is ready again the next cycle. A word with action = test
// carries a box; the block checks it against the six planes V3 +/- V0..V2 and
// returns one word on the output channel (out_valid/out_ready): visible = 1
// when the box passes all planes.
// A test runs through the states in order: S_RUN issues the six planes, one
// after the other, to the shared three-multiplier dot product unit, S_FLUSH
// drains the last plane check, and S_DONE loads the output register. in_ready
// is low while a test is at work, so no new word is accepted until the test
// has left S_DONE.
// The output register holds a finished result while the receiver stalls;
// the next word is still accepted, and a following test waits at its end
// until the output register is free.
// Reset empties the output register and returns the sequencer to idle. The
// matrix vectors are not cleared: load all four before the first test.
module frustum_box_cull #(
  parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = fbc_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [1:0]                    vec_index,
  input  logic signed [COORD_WIDTH-1:0] vx,
  input  logic signed [COORD_WIDTH-1:0] vy,
  input  logic signed [COORD_WIDTH-1:0] vz,
  input  logic signed [COORD_WIDTH-1:0] vw,
  input  logic signed [COORD_WIDTH-1:0] box_min_x,
  input  logic signed [COORD_WIDTH-1:0] box_min_y,
  input  logic signed [COORD_WIDTH-1:0] box_min_z,
  input  logic signed [COORD_WIDTH-1:0] box_max_x,
  input  logic signed [COORD_WIDTH-1:0] box_max_y,
  input  logic signed [COORD_WIDTH-1:0] box_max_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          visible
);
  import fbc_pkg::*;

  localparam int PW = COORD_WIDTH + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_FLUSH = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic signed [COORD_WIDTH-1:0] mat [VEC_COUNT][VEC_COUNT];
  logic signed [COORD_WIDTH-1:0] box_lo [AXIS_COUNT];
  logic signed [COORD_WIDTH-1:0] box_hi [AXIS_COUNT];
  logic signed [PW-1:0]          plane [VEC_COUNT];
  logic [2:0]                    plane_cnt;
  logic [1:0]                    axis;
  logic                          chk_q;
  logic                          in_fire;
  logic                          out_free;
  logic                          all_pass;
  fbc_ctl_t                      ctl;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign axis     = plane_cnt[2:1];

  always_ff @(posedge clk) begin
    if (in_fire && action == ACT_LOAD) begin
      mat[vec_index][0] <= vx;
      mat[vec_index][1] <= vy;
      mat[vec_index][2] <= vz;
      mat[vec_index][3] <= vw;
    end
    if (in_fire && action == ACT_TEST) begin
      box_lo[0] <= box_min_x;
      box_lo[1] <= box_min_y;
      box_lo[2] <= box_min_z;
      box_hi[0] <= box_max_x;
      box_hi[1] <= box_max_y;
      box_hi[2] <= box_max_z;
    end
  end

  // even plane count adds the axis vector, odd subtracts it
  always_comb begin
    for (int k = 0; k < VEC_COUNT; k++) begin
      if (plane_cnt[0]) begin
        plane[k] = PW'(mat[VEC_COUNT-1][k]) - PW'(mat[axis][k]);
      end else begin
        plane[k] = PW'(mat[VEC_COUNT-1][k]) + PW'(mat[axis][k]);
      end
    end
  end

  always_comb begin
    ctl.clear = in_fire && action == ACT_TEST;
    ctl.load  = (state == S_RUN);
    ctl.check = chk_q;
  end

  fbc_plane_unit #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_plane (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .plane   (plane),
    .box_lo  (box_lo),
    .box_hi  (box_hi),
    .all_pass(all_pass)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && action == ACT_TEST) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (plane_cnt == 3'(PLANE_COUNT - 1)) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      plane_cnt <= '0;
      chk_q     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      chk_q <= (state == S_RUN);
      if (state == S_RUN) begin
        plane_cnt <= plane_cnt + 3'd1;
      end else begin
        plane_cnt <= '0;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      visible <= all_pass;
    end
  end

endmodule

// File: rtl/core/fbc_checker.sv
module fbc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic action,
  input logic out_valid,
  input logic out_ready,
  input logic visible
);
  import fbc_pkg::*;

  // output register empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(visible))
    else $error("stalled result changed");

  // a test keeps the input side closed while it works
  a_test_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == ACT_TEST |=> !in_ready ##1 !in_ready)
    else $error("input reopened during a test");

  // a load leaves the block ready
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == ACT_LOAD |=> in_ready)
    else $error("block busy after a load");

  // no result word appears within the first cycles of a test
  a_test_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == ACT_TEST && !out_valid |=> !out_valid ##1 !out_valid)
    else $error("result appeared too early");

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .action   (action),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .visible  (visible)
);

// File: dv/frustum_box_cull_checker.sv
`timescale 1ns / 1ps

module frustum_box_cull_checker (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  input  logic                                       in_ready,
  input  logic                                       action,
  input  logic [1:0]                                 vec_index,
  input  logic signed [fbc_pkg::COORD_WIDTH_DEF-1:0] vx,
  input  logic signed [fbc_pkg::COORD_WIDTH_DEF-1:0] vy,
  input  logic signed [fbc_pkg::COORD_WIDTH_DEF-1:0] vz,
  input  logic signed [fbc_pkg::COORD_WIDTH_DEF-1:0] vw,
  input  logic signed [fbc_pkg::COORD_WIDTH_DEF-1:0] box_min_x,
  input  logic signed [fbc_pkg::COORD_WIDTH_DEF-1:0] box_min_y,
  input  logic signed [fbc_pkg::COORD_WIDTH_DEF-1:0] box_min_z,
  input  logic signed [fbc_pkg::COORD_WIDTH_DEF-1:0] box_max_x,
  input  logic signed [fbc_pkg::COORD_WIDTH_DEF-1:0] box_max_y,
  input  logic signed [fbc_pkg::COORD_WIDTH_DEF-1:0] box_max_z,
  input  logic                                       out_valid,
  input  logic                                       out_ready,
  input  logic                                       visible,
  output int                                         fail_count,
  output int                                         words_pending
);

  localparam int CW   = fbc_pkg::COORD_WIDTH_DEF;
  localparam int FRAC = fbc_pkg::FRAC_BITS_DEF;

  logic signed [CW-1:0] frustum_vec [fbc_pkg::VEC_COUNT][4];
  bit                   visible_expect_q [$];

  function automatic bit box_visible(input logic signed [CW-1:0] lx, ly, lz, hx, hy, hz);
    logic signed [CW-1:0]  lo [3];
    logic signed [CW-1:0]  hi [3];
    logic signed [CW:0]    plane [4];
    logic signed [CW:0]    base, axis_term;
    logic signed [127:0]   acc, coef, corner;
    bit                    vis;
    vis   = 1'b1;
    lo[0] = lx;
    lo[1] = ly;
    lo[2] = lz;
    hi[0] = hx;
    hi[1] = hy;
    hi[2] = hz;
    for (int ax = 0; ax < fbc_pkg::AXIS_COUNT; ax++) begin
      for (int side = 0; side < 2; side++) begin
        for (int k = 0; k < 4; k++) begin
          base      = frustum_vec[3][k];
          axis_term = frustum_vec[ax][k];
          plane[k]  = (side == 0) ? base + axis_term : base - axis_term;
        end
        acc = plane[3];
        acc = acc <<< FRAC;
        for (int k = 0; k < 3; k++) begin
          coef = plane[k];
          if (plane[k] > 0) begin
            corner = hi[k];
          end else begin
            corner = lo[k];
          end
          acc = acc + coef * corner;
        end
        if (acc < 0) begin
          vis = 1'b0;
        end
      end
    end
    return vis;
  endfunction

  always @(posedge clk) begin
    bit exp_vis;
    if (rst) begin
      visible_expect_q.delete();
      fail_count    = 0;
      words_pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (visible_expect_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual visible=%0b",
                   $time, visible);
          fail_count++;
        end else begin
          exp_vis = visible_expect_q.pop_front();
          if (visible !== exp_vis) begin
            $display("%0t: visible mismatch, expected %0b, actual %0b",
                     $time, exp_vis, visible);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (action == fbc_pkg::ACT_LOAD) begin
          frustum_vec[vec_index][0] = vx;
          frustum_vec[vec_index][1] = vy;
          frustum_vec[vec_index][2] = vz;
          frustum_vec[vec_index][3] = vw;
        end else begin
          visible_expect_q = {visible_expect_q,
                              box_visible(box_min_x, box_min_y, box_min_z,
                                          box_max_x, box_max_y, box_max_z)};
        end
      end
      words_pending = visible_expect_q.size();
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fbc_pkg::*;

  localparam int CW              = COORD_WIDTH_DEF;
  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 10;
  localparam int PHASE_WORDS     = 430;
  localparam int BURST_WORDS     = 24;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT  = 5000;

  localparam logic signed [CW-1:0] ONE  = 32'sh0001_0000;
  localparam logic signed [CW-1:0] CMIN = 32'sh8000_0000;
  localparam logic signed [CW-1:0] CMAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic                 act;
    logic [1:0]           idx;
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic signed [CW-1:0] vz;
    logic signed [CW-1:0] vw;
    logic signed [CW-1:0] min_x;
    logic signed [CW-1:0] min_y;
    logic signed [CW-1:0] min_z;
    logic signed [CW-1:0] max_x;
    logic signed [CW-1:0] max_y;
    logic signed [CW-1:0] max_z;
  } cull_word_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic                 action;
  logic [1:0]           vec_index;
  logic signed [CW-1:0] vx, vy, vz, vw;
  logic signed [CW-1:0] box_min_x, box_min_y, box_min_z;
  logic signed [CW-1:0] box_max_x, box_max_y, box_max_z;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 visible;

  int fail_count;
  int words_pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  cull_word_t directed_q [$];

  always #CLK_HALF clk = ~clk;

  frustum_box_cull u_dut (.*);

  frustum_box_cull_checker u_checker (.*);

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_word(input cull_word_t wd);
    directed_q = {directed_q, wd};
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(3))
          0: return CMIN;
          1: return CMAX;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return int'($urandom_range(16 << FRAC_BITS_DEF)) - (8 << FRAC_BITS_DEF);
    endcase
  endfunction

  function automatic cull_word_t random_word();
    cull_word_t           wd;
    logic signed [CW-1:0] c, h;
    wd.act = ($urandom_range(99) < 15) ? ACT_LOAD : ACT_TEST;
    wd.idx = $urandom_range(3);
    wd.vx  = rand_coord();
    wd.vy  = rand_coord();
    wd.vz  = rand_coord();
    wd.vw  = rand_coord();
    if ($urandom_range(9) == 0) begin
      wd.min_x = rand_coord();
      wd.min_y = rand_coord();
      wd.min_z = rand_coord();
      wd.max_x = rand_coord();
      wd.max_y = rand_coord();
      wd.max_z = rand_coord();
    end else begin
      c = rand_coord();
      h = $urandom_range(4 << FRAC_BITS_DEF);
      wd.min_x = c - h;
      wd.max_x = c + h;
      c = rand_coord();
      h = $urandom_range(4 << FRAC_BITS_DEF);
      wd.min_y = c - h;
      wd.max_y = c + h;
      c = rand_coord();
      h = $urandom_range(4 << FRAC_BITS_DEF);
      wd.min_z = c - h;
      wd.max_z = c + h;
    end
    return wd;
  endfunction

  function automatic cull_word_t make_load(input logic [1:0] idx,
                                           input logic signed [CW-1:0] x, y, z, w);
    cull_word_t wd;
    wd       = random_word();
    wd.act   = ACT_LOAD;
    wd.idx   = idx;
    wd.vx    = x;
    wd.vy    = y;
    wd.vz    = z;
    wd.vw    = w;
    return wd;
  endfunction

  function automatic cull_word_t make_test(input logic signed [CW-1:0] lx, ly, lz, hx, hy, hz);
    cull_word_t wd;
    wd       = random_word();
    wd.act   = ACT_TEST;
    wd.min_x = lx;
    wd.min_y = ly;
    wd.min_z = lz;
    wd.max_x = hx;
    wd.max_y = hy;
    wd.max_z = hz;
    return wd;
  endfunction

  task automatic send_word(input cull_word_t wd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    action    <= wd.act;
    vec_index <= wd.idx;
    vx        <= wd.vx;
    vy        <= wd.vy;
    vz        <= wd.vz;
    vw        <= wd.vw;
    box_min_x <= wd.min_x;
    box_min_y <= wd.min_y;
    box_min_z <= wd.min_z;
    box_max_x <= wd.max_x;
    box_max_y <= wd.max_y;
    box_max_z <= wd.max_z;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
  endtask

  initial begin
    cull_word_t wd;
    rst       = 1'b1;
    in_valid  = 1'b0;
    action    = ACT_LOAD;
    vec_index = '0;
    vx        = '0;
    vy        = '0;
    vz        = '0;
    vw        = '0;
    box_min_x = '0;
    box_min_y = '0;
    box_min_z = '0;
    box_max_x = '0;
    box_max_y = '0;
    box_max_z = '0;

    queue_word(make_load(2'd0, ONE, 0, 0, 0));
    queue_word(make_load(2'd1, 0, ONE, 0, 0));
    queue_word(make_load(2'd2, 0, 0, ONE, 0));
    queue_word(make_load(2'd3, 0, 0, 0, ONE));
    queue_word(make_test(-ONE / 2, -ONE / 2, -ONE / 2, ONE / 2, ONE / 2, ONE / 2));
    queue_word(make_test(2 * ONE, 0, 0, 3 * ONE, 0, 0));
    queue_word(make_test(-4 * ONE, -4 * ONE, -4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE));
    queue_word(make_test(ONE, ONE, ONE, -ONE, -ONE, -ONE));
    queue_word(make_test(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    queue_word(make_test(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
    queue_word(make_test(0, 0, 0, 0, 0, 0));
    queue_word(make_load(2'd0, 0, 0, 0, 0));
    queue_word(make_test(3 * ONE, 0, 0, 5 * ONE, 0, 0));
    for (int v = 0; v < VEC_COUNT; v++) begin
      queue_word(make_load(v[1:0], CMIN, CMIN, CMIN, CMIN));
    end
    queue_word(make_test(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    queue_word(make_test(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    for (int v = 0; v < VEC_COUNT; v++) begin
      queue_word(make_load(v[1:0], CMAX, CMAX, CMAX, CMAX));
    end
    queue_word(make_test(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    queue_word(make_test(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_q[i]) send_word(directed_q[i]);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) send_word(random_word());
      if (ph == 0) begin
        // empty the block, then stall the receiver while tests keep coming
        wait_results_done();
        @(posedge clk);
        hold_req++;
        @(negedge clk);
        for (int n = 0; n < BURST_WORDS; n++) begin
          wd     = random_word();
          wd.act = ACT_TEST;
          send_word(wd);
        end
      end
    end

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
